// ===== hdl/lucas_lehmer_mersenne_residue_top_assert.svh =====
// Assertion macros for the Lucas-Lehmer residue engine checker.
// Used by the checker file only; no dependencies.
`ifndef LUCAS_LEHMER_MERSENNE_RESIDUE_TOP_ASSERT_SVH
`define LUCAS_LEHMER_MERSENNE_RESIDUE_TOP_ASSERT_SVH

// Same-cycle implication, held off while reset is active.
`define LLMR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("llmr assertion failed");

// Next-cycle implication, held off while reset is active.
`define LLMR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("llmr assertion failed");

`endif

// ===== hdl/llmr_pkg.sv =====
// Shared widths and defaults for the Lucas-Lehmer residue engine.
// No dependencies.
`default_nettype none

package llmr_pkg;

    localparam int MAX_EXPONENT_DEF = 1024;
    localparam int LIMB_BITS        = 64;
    localparam int DIG_BITS         = 32;
    localparam int DIG_SH           = 5;
    localparam int EXP_W            = 11;
    localparam int LIMB_IDX_W       = 4;
    localparam int ITER_W           = 11;

endpackage

`default_nettype wire

// ===== hdl/lucas_lehmer_mersenne_residue_top.sv =====
// Lucas-Lehmer residue engine: s = s*s - 2 mod 2^p-1, p-2 times, from s = 4.
// Depends on llmr_pkg.
//
//  channel  direction  handshake                 payload
//  input    in         i_in_valid / o_in_ready   i_exponent
//  output   out        o_out_valid / i_out_ready limb index, limb value, flags
//
// One exponent at a time; o_in_ready is high only while idle.
// Squaring uses one 32x32 multiplier over m = ceil(p/32) digits, issuing m*m
// products per squaring; a fold pass and one or two subtract passes follow it.
// A rejected exponent gives its single result in the cycle after the transfer.
// Reset is synchronous; a stalled output holds its result and the engine waits.
`default_nettype none

module lucas_lehmer_mersenne_residue_top #(
    parameter int MAX_EXPONENT = llmr_pkg::MAX_EXPONENT_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [llmr_pkg::EXP_W-1:0]        i_exponent,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [llmr_pkg::LIMB_IDX_W-1:0]        o_limb_index,
    output logic [llmr_pkg::LIMB_BITS-1:0]         o_limb_value,
    output logic                                   o_residue_zero,
    output logic                                   o_bad_exponent,
    output logic                                   o_last
);

    localparam int DIG  = llmr_pkg::DIG_BITS;
    localparam int MAXD = (MAX_EXPONENT + DIG - 1) / DIG;
    localparam int DW   = (MAXD > 1) ? $clog2(MAXD) : 1;
    localparam int PW   = $clog2(2 * MAXD);
    localparam int CW   = PW + 2;
    localparam int AW   = 2 * DIG + PW + 2;
    localparam int EW   = llmr_pkg::EXP_W;
    localparam int QW   = EW - llmr_pkg::DIG_SH;
    localparam int RW   = llmr_pkg::DIG_SH;
    localparam int IW   = llmr_pkg::ITER_W;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_INIT    = 4'd1;
    localparam logic [3:0] S_SQ      = 4'd2;
    localparam logic [3:0] S_SQDRAIN = 4'd3;
    localparam logic [3:0] S_SQTAIL  = 4'd4;
    localparam logic [3:0] S_FPRIME  = 4'd5;
    localparam logic [3:0] S_FISSUE  = 4'd6;
    localparam logic [3:0] S_FCALC   = 4'd7;
    localparam logic [3:0] S_BISSUE  = 4'd8;
    localparam logic [3:0] S_BCALC   = 4'd9;
    localparam logic [3:0] S_ZISSUE  = 4'd10;
    localparam logic [3:0] S_ZCALC   = 4'd11;
    localparam logic [3:0] S_ORD     = 4'd12;
    localparam logic [3:0] S_OLD     = 4'd13;
    localparam logic [3:0] S_OWAIT   = 4'd14;

    // storage
    logic [DIG-1:0] r_res_mem  [MAXD];
    logic [DIG-1:0] r_prod_mem [2*MAXD];

    logic [3:0]      r_state;
    logic [EW-1:0]   r_p;
    logic [DW:0]     r_m;
    logic [QW-1:0]   r_q;
    logic [RW-1:0]   r_r;
    logic [DIG-1:0]  r_top;
    logic [IW-1:0]   r_iter;
    logic [CW-1:0]   r_cnt;
    logic [CW-1:0]   r_gk;
    logic [CW-1:0]   r_gi;
    logic [PW-1:0]   r_kw;
    logic [DIG-1:0]  r_rda;
    logic [DIG-1:0]  r_rdb;
    logic [DIG-1:0]  r_pda;
    logic [DIG-1:0]  r_pdb;
    logic            r_zb;
    logic            r_v1, r_e1, r_f1;
    logic            r_v2, r_e2, r_f2;
    logic [2*DIG-1:0] r_prod;
    logic [AW-1:0]   r_acc;
    logic [DIG-1:0]  r_hprev;
    logic            r_carry;
    logic            r_borrow;
    logic            r_second;
    logic [1:0]      r_sub;
    logic            r_nz;
    logic            r_out_valid;
    logic [llmr_pkg::LIMB_IDX_W-1:0] r_o_idx;
    logic [llmr_pkg::LIMB_BITS-1:0]  r_o_val;
    logic            r_o_zero;
    logic            r_o_bad;
    logic            r_o_last;

    // input decode
    logic [EW+1:0]  w_e_ext;
    logic [EW+1:0]  w_mfull;
    logic           w_bad;
    logic [RW-1:0]  w_r_in;
    assign w_e_ext = {2'b00, i_exponent};
    assign w_mfull = (w_e_ext + (EW+2)'(DIG - 1)) >> llmr_pkg::DIG_SH;
    assign w_bad   = (i_exponent < EW'(2)) || (32'(i_exponent) > MAX_EXPONENT);
    assign w_r_in  = i_exponent[RW-1:0];

    // digit counts
    logic [CW-1:0] w_m_c, w_mm1, w_n_c, w_last_col;
    assign w_m_c      = CW'(r_m);
    assign w_mm1      = w_m_c - CW'(1);
    assign w_n_c      = (w_m_c + CW'(1)) >> 1;
    assign w_last_col = (w_m_c << 1) - CW'(2);

    // product-scanning address generator
    logic [CW-1:0] w_imax, w_gj, w_gk1, w_inext;
    logic          w_col_end, w_final;
    assign w_imax    = (r_gk >= w_mm1) ? w_mm1 : r_gk;
    assign w_gj      = r_gk - r_gi;
    assign w_col_end = (r_gi == w_imax);
    assign w_final   = w_col_end && (r_gk == w_last_col);
    assign w_gk1     = r_gk + CW'(1);
    assign w_inext   = (w_gk1 >= w_m_c) ? (w_gk1 - w_mm1) : CW'(0);

    // column accumulate
    logic [AW-1:0] w_sum;
    assign w_sum = r_acc + AW'(r_prod);

    // fold digit
    logic            w_cnt_last;
    logic [DIG-1:0]  w_pdb_eff, w_h, w_low;
    logic [2*DIG-1:0] w_hcat;
    logic [DIG+1:0]  w_fsum;
    logic            w_extra;
    assign w_cnt_last = (r_cnt == w_mm1);
    assign w_pdb_eff  = r_zb ? '0 : r_pdb;
    assign w_hcat     = {w_pdb_eff, r_hprev} >> r_r;
    assign w_h        = w_hcat[DIG-1:0];
    assign w_low      = w_cnt_last ? (r_pda & r_top) : r_pda;
    assign w_fsum     = (DIG+2)'(w_low) + (DIG+2)'(w_h) + (DIG+2)'(r_carry);
    assign w_extra    = (r_r == '0) ? w_fsum[DIG] : w_fsum[r_r];

    // subtract pass digit
    logic [DIG:0]   w_diff;
    logic [DIG-1:0] w_bsub;
    assign w_bsub = (r_cnt == '0) ? DIG'(r_sub) : '0;
    assign w_diff = {1'b0, r_rda} - (DIG+1)'(w_bsub) - (DIG+1)'(r_borrow);

    // output digit selection
    logic [CW-1:0] w_olo, w_ohi;
    assign w_olo = r_cnt << 1;
    assign w_ohi = w_olo + CW'(1);

    // memory ports
    logic           w_rwe;
    logic [DW-1:0]  w_rwa, w_ra, w_rb;
    logic [DIG-1:0] w_rwd;
    logic           w_pwe;
    logic [PW-1:0]  w_pwa, w_pa, w_pb;
    logic [DIG-1:0] w_pwd;
    logic [CW-1:0]  w_pb_full;
    logic           w_pb_zero;

    assign w_pb_full = CW'(r_q) + r_cnt + ((r_state == S_FPRIME) ? CW'(0) : CW'(1));
    assign w_pb_zero = (w_pb_full >= (w_m_c << 1));
    assign w_pa      = r_cnt[PW-1:0];
    assign w_pb      = w_pb_full[PW-1:0];
    assign w_pwe     = (r_v2 && r_e2) || (r_state == S_SQTAIL);
    assign w_pwa     = r_kw;
    assign w_pwd     = (r_state == S_SQTAIL) ? r_acc[DIG-1:0] : w_sum[DIG-1:0];

    always_comb begin
        w_rwe = 1'b0;
        w_rwa = r_cnt[DW-1:0];
        w_rwd = '0;
        w_ra  = r_cnt[DW-1:0];
        w_rb  = r_cnt[DW-1:0];
        case (r_state)
            S_INIT: begin
                w_rwe = 1'b1;
                if (r_cnt == '0) begin
                    w_rwd = (r_p == EW'(2)) ? DIG'(1) : DIG'(4);
                end
            end
            S_SQ: begin
                w_ra = r_gi[DW-1:0];
                w_rb = w_gj[DW-1:0];
            end
            S_FCALC: begin
                w_rwe = 1'b1;
                w_rwd = w_cnt_last ? (w_fsum[DIG-1:0] & r_top) : w_fsum[DIG-1:0];
            end
            S_BCALC: begin
                w_rwe = 1'b1;
                w_rwd = w_cnt_last ? (w_diff[DIG-1:0] & r_top) : w_diff[DIG-1:0];
            end
            S_ORD: begin
                w_ra = w_olo[DW-1:0];
                w_rb = w_ohi[DW-1:0];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_rwe) begin
            r_res_mem[w_rwa] <= w_rwd;
        end
        r_rda <= r_res_mem[w_ra];
        r_rdb <= r_res_mem[w_rb];
    end

    always_ff @(posedge i_clk) begin
        if (w_pwe) begin
            r_prod_mem[w_pwa] <= w_pwd;
        end
        r_pda <= r_prod_mem[w_pa];
        r_pdb <= r_prod_mem[w_pb];
        r_zb  <= w_pb_zero;
    end

    // multiplier pipeline: read, multiply, accumulate
    always_ff @(posedge i_clk) begin
        r_prod <= r_rda * r_rdb;
        r_e1   <= w_col_end;
        r_f1   <= w_final;
        r_e2   <= r_e1;
        r_f2   <= r_f1;
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= (r_state == S_SQ);
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_iter      <= '0;
        end else begin
            if (r_v2) begin
                if (r_e2) begin
                    r_acc <= w_sum >> DIG;
                    r_kw  <= r_kw + PW'(1);
                end else begin
                    r_acc <= w_sum;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (w_bad) begin
                            r_o_idx     <= '0;
                            r_o_val     <= '0;
                            r_o_zero    <= 1'b0;
                            r_o_bad     <= 1'b1;
                            r_o_last    <= 1'b1;
                            r_out_valid <= 1'b1;
                            r_state     <= S_OWAIT;
                        end else begin
                            r_p     <= i_exponent;
                            r_m     <= w_mfull[DW:0];
                            r_q     <= i_exponent[EW-1:RW];
                            r_r     <= w_r_in;
                            r_top   <= (w_r_in == '0) ? '1 : ((DIG'(1) << w_r_in) - DIG'(1));
                            r_cnt   <= '0;
                            r_iter  <= '0;
                            r_state <= S_INIT;
                        end
                    end
                end
                S_INIT: begin
                    if (w_cnt_last) begin
                        r_cnt <= '0;
                        if (r_p == EW'(2)) begin
                            r_nz    <= 1'b0;
                            r_state <= S_ZISSUE;
                        end else begin
                            r_gk    <= '0;
                            r_gi    <= '0;
                            r_acc   <= '0;
                            r_kw    <= '0;
                            r_state <= S_SQ;
                        end
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_SQ: begin
                    if (w_final) begin
                        r_state <= S_SQDRAIN;
                    end else if (w_col_end) begin
                        r_gk <= w_gk1;
                        r_gi <= w_inext;
                    end else begin
                        r_gi <= r_gi + CW'(1);
                    end
                end
                S_SQDRAIN: begin
                    if (r_v2 && r_f2) begin
                        r_state <= S_SQTAIL;
                    end
                end
                S_SQTAIL: begin
                    r_cnt   <= '0;
                    r_carry <= 1'b0;
                    r_state <= S_FPRIME;
                end
                S_FPRIME: begin
                    r_state <= S_FISSUE;
                end
                S_FISSUE: begin
                    r_hprev <= w_pdb_eff;
                    r_state <= S_FCALC;
                end
                S_FCALC: begin
                    r_carry <= w_fsum[DIG];
                    if (w_cnt_last) begin
                        // fold the bit above position p back in, then take 2 off
                        r_sub    <= w_extra ? 2'd1 : 2'd2;
                        r_borrow <= 1'b0;
                        r_second <= 1'b0;
                        r_cnt    <= '0;
                        r_state  <= S_BISSUE;
                    end else begin
                        r_cnt   <= r_cnt + CW'(1);
                        r_state <= S_FISSUE;
                    end
                end
                S_BISSUE: begin
                    r_state <= S_BCALC;
                end
                S_BCALC: begin
                    r_borrow <= w_diff[DIG];
                    if (w_cnt_last) begin
                        r_cnt <= '0;
                        if (w_diff[DIG] && !r_second) begin
                            // wrapped below zero: one more off gives s + M - 2
                            r_second <= 1'b1;
                            r_sub    <= 2'd1;
                            r_borrow <= 1'b0;
                            r_state  <= S_BISSUE;
                        end else begin
                            r_iter <= r_iter + IW'(1);
                            if ((r_iter + IW'(1)) == IW'(r_p - EW'(2))) begin
                                r_nz    <= 1'b0;
                                r_state <= S_ZISSUE;
                            end else begin
                                r_gk    <= '0;
                                r_gi    <= '0;
                                r_acc   <= '0;
                                r_kw    <= '0;
                                r_state <= S_SQ;
                            end
                        end
                    end else begin
                        r_cnt   <= r_cnt + CW'(1);
                        r_state <= S_BISSUE;
                    end
                end
                S_ZISSUE: begin
                    r_state <= S_ZCALC;
                end
                S_ZCALC: begin
                    r_nz <= r_nz || (r_rda != '0);
                    if (w_cnt_last) begin
                        r_cnt   <= '0;
                        r_state <= S_ORD;
                    end else begin
                        r_cnt   <= r_cnt + CW'(1);
                        r_state <= S_ZISSUE;
                    end
                end
                S_ORD: begin
                    r_state <= S_OLD;
                end
                S_OLD: begin
                    r_o_idx     <= r_cnt[llmr_pkg::LIMB_IDX_W-1:0];
                    r_o_val     <= {((w_ohi < w_m_c) ? r_rdb : DIG'(0)), r_rda};
                    r_o_zero    <= !r_nz;
                    r_o_bad     <= 1'b0;
                    r_o_last    <= (r_cnt == (w_n_c - CW'(1)));
                    r_out_valid <= 1'b1;
                    r_state     <= S_OWAIT;
                end
                S_OWAIT: begin
                    if (i_out_ready) begin
                        r_out_valid <= 1'b0;
                        if (r_o_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_cnt   <= r_cnt + CW'(1);
                            r_state <= S_ORD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_limb_index   = r_o_idx;
    assign o_limb_value   = r_o_val;
    assign o_residue_zero = r_o_zero;
    assign o_bad_exponent = r_o_bad;
    assign o_last         = r_o_last;

endmodule

`default_nettype wire

// ===== hdl/llmr_checker.sv =====
// Port-level checker for the Lucas-Lehmer residue engine, bound to the top.
// Depends on llmr_pkg and lucas_lehmer_mersenne_residue_top_assert.svh.
`default_nettype none

`include "lucas_lehmer_mersenne_residue_top_assert.svh"

module llmr_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_in_valid,
    input wire logic                              o_in_ready,
    input wire logic                              o_out_valid,
    input wire logic                              i_out_ready,
    input wire logic [llmr_pkg::LIMB_IDX_W-1:0]   o_limb_index,
    input wire logic [llmr_pkg::LIMB_BITS-1:0]    o_limb_value,
    input wire logic                              o_bad_exponent,
    input wire logic                              o_last
);

    // a stalled result holds
    `LLMR_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_limb_value))

    // a rejected exponent gives one empty limb
    `LLMR_ASSERT_IMP(a_bad_shape, i_clk, i_rst_n, o_out_valid && o_bad_exponent, o_last && (o_limb_index == '0) && (o_limb_value == '0))

    // one exponent at a time
    `LLMR_ASSERT_IMP(a_busy_out, i_clk, i_rst_n, o_out_valid, !o_in_ready)
    `LLMR_ASSERT_NXT(a_busy_in, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)

    // more limbs follow: stay busy
    `LLMR_ASSERT_NXT(a_busy_limbs, i_clk, i_rst_n, o_out_valid && i_out_ready && !o_last, !o_in_ready)

endmodule

bind lucas_lehmer_mersenne_residue_top llmr_checker u_llmr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_limb_index   (o_limb_index),
    .o_limb_value   (o_limb_value),
    .o_bad_exponent (o_bad_exponent),
    .o_last         (o_last)
);

`default_nettype wire
